FILE: rtl/pcrdc_pkg.sv
// shared types and constants for the per-core report dedup counter
package pcrdc_pkg;

  localparam int unsigned CORE_SEL_W = 4;
  localparam int unsigned NUM_SEL    = 2 ** CORE_SEL_W;
  localparam int unsigned REC_W      = 64;
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned SIZE_W     = 8;
  localparam int unsigned PC_W       = 32;
  localparam int unsigned KEY_W      = TYPE_W + SIZE_W + PC_W;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ENT_W      = CNT_W + KEY_W;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned FILL_OUT_W = 7;
  localparam int unsigned TOTAL_W    = 32;

  // fields declared in reverse so that core_select, the first field on the bus, sits in the lowest bits
  typedef struct packed {
    logic [REC_W-1:0]      second_access_rest;
    logic [PC_W-1:0]       second_access_pc;
    logic [SIZE_W-1:0]     second_access_size;
    logic [TYPE_W-1:0]     second_access_type;
    logic [REC_W-1:0]      first_access_record;
    logic [CORE_SEL_W-1:0] core_select;
  } req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]    total_reports;
    logic                  table_full;
    logic [FILL_OUT_W-1:0] core_fill;
    logic [CNT_W-1:0]      occurrence_count;
    logic [SLOT_OUT_W-1:0] entry_slot;
    logic                  matched;
  } res_t;

  localparam int unsigned REQ_W       = $bits(req_t);
  localparam int unsigned RES_W       = $bits(res_t);
  localparam int unsigned S_TDATA_W   = ((REQ_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W   = ((RES_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESP
  } state_e;

endpackage

FILE: rtl/per_core_report_dedup_counter_top.sv
// top level of the per-core race report dedup counter
//
// one race report enters on the s_axis channel and one result leaves on the
// m_axis channel for every report. each core owns ENTRIES_PER_CORE slots in a
// shared entry memory keyed by second-access type, size and pc; the record
// memory keeps the opaque first-access record and second-access rest.
// a report's search reads only the filled slots of its core, so at most
// ENTRIES_PER_CORE of them:
// the search reads one slot per cycle through the single entry memory read
// port, then the response state writes the count or the new entry back.
// one report is in flight at a time; s_axis_tready is high while idle.
// the result sits in an output register, so a new report is taken while an
// earlier result waits; a stalled receiver holds the finished result of the
// next report inside the block and stops further acceptance.
// reset clears fill levels, the report total and all handshake state; the
// memories need no clearing since only filled slots are ever read.
module per_core_report_dedup_counter_top #(
  parameter int unsigned CORES            = 16,
  parameter int unsigned ENTRIES_PER_CORE = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // core_select, first_access_record, second_access_type,
  // second_access_size, second_access_pc, second_access_rest, zero pad
  input  logic [pcrdc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // matched, entry_slot, occurrence_count, core_fill, table_full,
  // total_reports, zero pad
  output logic [pcrdc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  import pcrdc_pkg::*;

  localparam int unsigned DEPTH  = CORES * ENTRIES_PER_CORE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              ent_re;
  logic [ADDR_W-1:0] ent_raddr;
  logic [ENT_W-1:0]  ent_rdata;
  logic              ent_we;
  logic              rec_we;
  logic [ADDR_W-1:0] waddr;
  logic [ENT_W-1:0]  ent_wdata;
  logic [2*REC_W-1:0] rec_wdata;

  logic              out_vld_q;
  res_t              out_q;

  assign req = req_t'(s_axis_tdata[REQ_W-1:0]);

  pcrdc_ctrl #(
    .CORES            (CORES),
    .ENTRIES_PER_CORE (ENTRIES_PER_CORE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ent_re_o    (ent_re),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata),
    .ent_we_o    (ent_we),
    .rec_we_o    (rec_we),
    .waddr_o     (waddr),
    .ent_wdata_o (ent_wdata),
    .rec_wdata_o (rec_wdata)
  );

  pcrdc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  pcrdc_ram #(
    .WIDTH (2 * REC_W),
    .DEPTH (DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (waddr),
    .wdata_i (rec_wdata),
    .re_i    (1'b0),
    .raddr_i (waddr),
    .rdata_o ()
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = M_TDATA_W'(out_q);

  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.matched && out_q.table_full))
    else $error("result flags both hit and table full");

  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.table_full) |->
      (out_q.core_fill == FILL_OUT_W'(ENTRIES_PER_CORE)))
    else $error("table full reported with table not at capacity");

  a_insert_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.matched && !out_q.table_full) |->
      ((out_q.occurrence_count == CNT_W'(1)) &&
       (out_q.entry_slot == SLOT_OUT_W'(out_q.core_fill - FILL_OUT_W'(1)))))
    else $error("new entry not placed at end of table with count one");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while search in progress");

endmodule

FILE: rtl/pcrdc_ram.sv
// simple dual-port synchronous ram with registered read data
module pcrdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pcrdc_ctrl.sv
// search sequencer, read-modify-write control, fill levels and report total
module pcrdc_ctrl #(
  parameter int unsigned CORES            = 16,
  parameter int unsigned ENTRIES_PER_CORE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  pcrdc_pkg::req_t       req_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output pcrdc_pkg::res_t       res_o,
  output logic                  ent_re_o,
  output logic [$clog2(CORES * ENTRIES_PER_CORE)-1:0] ent_raddr_o,
  input  logic [pcrdc_pkg::ENT_W-1:0] ent_rdata_i,
  output logic                  ent_we_o,
  output logic                  rec_we_o,
  output logic [$clog2(CORES * ENTRIES_PER_CORE)-1:0] waddr_o,
  output logic [pcrdc_pkg::ENT_W-1:0] ent_wdata_o,
  output logic [2*pcrdc_pkg::REC_W-1:0] rec_wdata_o
);

  import pcrdc_pkg::*;

  localparam int unsigned CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int unsigned SLOT_W = $clog2(ENTRIES_PER_CORE);
  localparam int unsigned FILL_W = $clog2(ENTRIES_PER_CORE + 1);
  localparam int unsigned ADDR_W = $clog2(CORES * ENTRIES_PER_CORE);

  state_e state_q, state_d;

  logic [CORE_W-1:0]  core_lut [NUM_SEL];
  logic [CORE_W-1:0]  core_sel;

  logic [CORE_W-1:0]  core_q, core_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [REC_W-1:0]   first_q, first_d;
  logic [REC_W-1:0]   rest_q, rest_d;
  logic [FILL_W-1:0]  fill_cur_q, fill_cur_d;
  logic [FILL_W-1:0]  fill_res_q, fill_res_d;
  logic [FILL_W-1:0]  idx_q, idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0]  rd_idx_q, rd_idx_d;
  logic               hit_q, hit_d;
  logic               full_q, full_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FILL_W-1:0]  fill_lvl_q [CORES];
  logic [TOTAL_W-1:0] total_q;

  logic               issue;
  logic               commit;
  logic               insert;

  for (genvar g = 0; g < NUM_SEL; g++) begin : g_core_lut
    assign core_lut[g] = CORE_W'(g % CORES);
  end

  assign core_sel = core_lut[req_i.core_select];
  assign issue    = (state_q == ST_SEARCH) && (idx_q < fill_cur_q);
  assign commit   = (state_q == ST_RESP) && res_ready_i;
  assign insert   = !hit_q && !full_q;

  always_comb begin
    state_d    = state_q;
    core_d     = core_q;
    base_d     = base_q;
    key_d      = key_q;
    first_d    = first_q;
    rest_d     = rest_q;
    fill_cur_d = fill_cur_q;
    fill_res_d = fill_res_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    full_d     = full_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          core_d     = core_sel;
          base_d     = ADDR_W'(core_sel * ENTRIES_PER_CORE);
          key_d      = {req_i.second_access_type, req_i.second_access_size,
                        req_i.second_access_pc};
          first_d    = req_i.first_access_record;
          rest_d     = req_i.second_access_rest;
          fill_cur_d = fill_lvl_q[core_sel];
          idx_d      = '0;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        rd_vld_d = issue;
        rd_idx_d = idx_q[SLOT_W-1:0];
        if (issue) begin
          idx_d = idx_q + FILL_W'(1);
        end
        if (rd_vld_q && (ent_rdata_i[KEY_W-1:0] == key_q)) begin
          hit_d      = 1'b1;
          full_d     = 1'b0;
          slot_d     = rd_idx_q;
          cnt_d      = ent_rdata_i[ENT_W-1 -: CNT_W] + CNT_W'(1);
          fill_res_d = fill_cur_q;
          state_d    = ST_RESP;
        end else if (!issue) begin
          hit_d = 1'b0;
          if (fill_cur_q == FILL_W'(ENTRIES_PER_CORE)) begin
            full_d     = 1'b1;
            slot_d     = '0;
            cnt_d      = '0;
            fill_res_d = fill_cur_q;
          end else begin
            full_d     = 1'b0;
            slot_d     = fill_cur_q[SLOT_W-1:0];
            cnt_d      = CNT_W'(1);
            fill_res_d = fill_cur_q + FILL_W'(1);
          end
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      total_q  <= '0;
      for (int i = 0; i < CORES; i++) begin
        fill_lvl_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      if (commit) begin
        total_q <= total_q + TOTAL_W'(1);
        if (insert) begin
          fill_lvl_q[core_q] <= fill_res_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    core_q     <= core_d;
    base_q     <= base_d;
    key_q      <= key_d;
    first_q    <= first_d;
    rest_q     <= rest_d;
    fill_cur_q <= fill_cur_d;
    fill_res_q <= fill_res_d;
    idx_q      <= idx_d;
    rd_idx_q   <= rd_idx_d;
    hit_q      <= hit_d;
    full_q     <= full_d;
    slot_q     <= slot_d;
    cnt_q      <= cnt_d;
  end

  assign ent_re_o    = issue;
  assign ent_raddr_o = base_q + ADDR_W'(idx_q[SLOT_W-1:0]);
  assign waddr_o     = base_q + ADDR_W'(slot_q);
  assign ent_we_o    = commit && !full_q;
  assign rec_we_o    = commit && insert;
  assign ent_wdata_o = {cnt_q, key_q};
  assign rec_wdata_o = {rest_q, first_q};

  assign res_o.matched          = hit_q;
  assign res_o.entry_slot       = SLOT_OUT_W'(slot_q);
  assign res_o.occurrence_count = cnt_q;
  assign res_o.core_fill        = FILL_OUT_W'(fill_res_q);
  assign res_o.table_full       = full_q;
  assign res_o.total_reports    = total_q + TOTAL_W'(1);

endmodule

FILE: tb/sv/per_core_report_dedup_counter_top_tb.sv
// testbench for the per-core race report dedup counter: predicts every result and checks it
module per_core_report_dedup_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcrdc_pkg::*;

  localparam int unsigned NUM_CORES    = 16;
  localparam int unsigned SLOTS        = 64;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_SHOWN    = 10;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  logic [KEY_W-1:0]   tab_key   [NUM_CORES][SLOTS];
  logic [CNT_W-1:0]   tab_count [NUM_CORES][SLOTS];
  int unsigned        tab_fill  [NUM_CORES] = '{default: 0};
  logic [TOTAL_W-1:0] report_count = '0;
  res_t               pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          tx_idle_on     = 1'b0;
  bit          rx_idle_on     = 1'b0;
  bit          long_hold_req  = 1'b0;
  int unsigned long_hold_left = 0;
  int unsigned rx_gap_left    = 0;

  always #5 clk_i = ~clk_i;

  per_core_report_dedup_counter_top #(
    .CORES           (NUM_CORES),
    .ENTRIES_PER_CORE(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  function automatic res_t predict_dedup(input req_t r);
    int unsigned      core;
    int unsigned      fill;
    int unsigned      hit_at;
    int unsigned      i;
    bit               hit;
    logic [KEY_W-1:0] key;
    res_t             res;
    core   = r.core_select % NUM_CORES;
    key    = {r.second_access_type, r.second_access_size, r.second_access_pc};
    fill   = tab_fill[core];
    hit    = 1'b0;
    hit_at = 0;
    res    = '0;
    for (i = 0; i < fill; i++) begin
      if (!hit && tab_key[core][i] == key) begin
        hit    = 1'b1;
        hit_at = i;
      end
    end
    if (hit) begin
      tab_count[core][hit_at] = tab_count[core][hit_at] + 1'b1;
      res.matched          = 1'b1;
      res.entry_slot       = hit_at[SLOT_OUT_W-1:0];
      res.occurrence_count = tab_count[core][hit_at];
    end else if (fill >= SLOTS) begin
      res.table_full = 1'b1;
    end else begin
      tab_key[core][fill]   = key;
      tab_count[core][fill] = 1;
      res.entry_slot        = fill[SLOT_OUT_W-1:0];
      res.occurrence_count  = 1;
      fill++;
      tab_fill[core] = fill;
    end
    res.core_fill     = fill[FILL_OUT_W-1:0];
    report_count      = report_count + 1'b1;
    res.total_reports = report_count;
    return res;
  endfunction

  function automatic req_t make_report(input logic [CORE_SEL_W-1:0] core,
                                       input logic [REC_W-1:0] first_rec,
                                       input logic [TYPE_W-1:0] acc_type,
                                       input logic [SIZE_W-1:0] acc_size,
                                       input logic [PC_W-1:0] pc,
                                       input logic [REC_W-1:0] rest);
    req_t r;
    r.core_select         = core;
    r.first_access_record = first_rec;
    r.second_access_type  = acc_type;
    r.second_access_size  = acc_size;
    r.second_access_pc    = pc;
    r.second_access_rest  = rest;
    return r;
  endfunction

  // repeats an existing key, nearly repeats one, or makes a fresh one
  function automatic req_t random_report(input int unsigned core, input int unsigned repeat_pct);
    int unsigned      fill;
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    fill = tab_fill[core];
    pick = $urandom_range(0, 99);
    key  = KEY_W'({$urandom(), $urandom()});
    if (fill != 0 && pick < repeat_pct) begin
      key = tab_key[core][$urandom_range(0, fill - 1)];
    end else if (fill != 0 && pick < repeat_pct + 15) begin
      key = tab_key[core][$urandom_range(0, fill - 1)];
      key[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
    end
    return make_report(core[CORE_SEL_W-1:0], {$urandom(), $urandom()},
                       key[KEY_W-1 -: TYPE_W], key[PC_W+SIZE_W-1 -: SIZE_W],
                       key[PC_W-1:0], {$urandom(), $urandom()});
  endfunction

  function automatic int unsigned random_core();
    if ($urandom_range(0, 9) < 4) begin
      return $urandom_range(0, 3);
    end
    return $urandom_range(0, NUM_CORES - 1);
  endfunction

  task automatic send_report(input req_t r);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(r);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_dedup(r));
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_report(make_report(4'd0, '0, 8'h00, 8'h00, 32'h0000_0000, '0));
    send_report(make_report(4'd0, '0, 8'h00, 8'h00, 32'h0000_0000, '0));
    send_report(make_report(4'd15, '1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, '1));
    send_report(make_report(4'd15, 64'h0123_4567_89AB_CDEF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                            64'hFEDC_BA98_7654_3210));
    send_report(make_report(4'd0, '1, 8'hFF, 8'h00, 32'h0000_0000, '1));
    send_report(make_report(4'd0, '0, 8'h00, 8'hFF, 32'h0000_0000, '0));
    send_report(make_report(4'd0, '1, 8'h00, 8'h00, 32'hFFFF_FFFF, '0));
    send_report(make_report(4'd0, '0, 8'h00, 8'h00, 32'h0000_0001, '1));
    send_report(make_report(4'd0, '0, 8'h00, 8'h00, 32'h8000_0000, '0));
    send_report(make_report(4'd0, '1, 8'h00, 8'h00, 32'h0000_0000, '1));
    send_report(make_report(4'd0, '0, 8'hFF, 8'h00, 32'h0000_0000, '0));
    send_report(make_report(4'd1, '0, 8'h00, 8'h00, 32'h0000_0000, '0));
    send_report(make_report(4'd8, 64'h5555_5555_5555_5555, 8'hA5, 8'h5A, 32'hAAAA_AAAA,
                            64'hAAAA_AAAA_AAAA_AAAA));
    send_report(make_report(4'd8, 64'hAAAA_AAAA_AAAA_AAAA, 8'h5A, 8'hA5, 32'h5555_5555,
                            64'h5555_5555_5555_5555));
    send_report(make_report(4'd8, '0, 8'hA5, 8'h5A, 32'hAAAA_AAAA, '1));
    send_report(make_report(4'd15, '0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, '0));
  endtask

  // fills one core's table, then mixes dropped new keys with hits on a full table
  task automatic test_table_overflow(input int unsigned core);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (tab_fill[core] < SLOTS) send_report(random_report(core, 25));
    send_report(random_report(core, 0));
    send_report(make_report(core[CORE_SEL_W-1:0], '1, tab_key[core][SLOTS-1][KEY_W-1 -: TYPE_W],
                            tab_key[core][SLOTS-1][PC_W+SIZE_W-1 -: SIZE_W],
                            tab_key[core][SLOTS-1][PC_W-1:0], '0));
    repeat (8) send_report(random_report(core, 50));
  endtask

  task automatic test_random_reports(input int unsigned n, input bit with_idle);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      tx_idle_on = with_idle && ((i / 50) % 3 != 2);
      rx_idle_on = with_idle && ((i / 50) % 3 != 1);
      send_report(random_report(random_core(), 55));
    end
  endtask

  // receiver holds off so the block backs up, then sender waits for every result
  task automatic test_backpressure();
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    long_hold_req = 1'b1;
    repeat (12) send_report(random_report($urandom_range(0, 3), 55));
    end_stream();
    wait_drain();
  endtask

  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req  = 1'b0;
      long_hold_left = LONG_HOLD;
    end
    if (long_hold_left != 0) begin
      long_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      rx_gap_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
        $display("mismatch on %s: expected %0h, got %0h", fname, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[RES_W-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("result with no request pending: %h", got);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("matched", 32'(want.matched), 32'(got.matched));
        check_field("entry_slot", 32'(want.entry_slot), 32'(got.entry_slot));
        check_field("occurrence_count", want.occurrence_count, got.occurrence_count);
        check_field("core_fill", 32'(want.core_fill), 32'(got.core_fill));
        check_field("table_full", 32'(want.table_full), 32'(got.table_full));
        check_field("total_reports", want.total_reports, got.total_reports);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_overflow(NUM_CORES - 1);
    test_table_overflow($urandom_range(1, NUM_CORES - 2));
    test_random_reports(550, 1'b1);
    test_backpressure();
    test_random_reports(150, 1'b0);
    end_stream();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
